### rtl/nfcs_pkg.sv
// Shared types and command constants for the NOR flash command sequencer.
package nfcs_pkg;

    // Request actions
    localparam logic [2:0] ACT_RESET   = 3'd0;
    localparam logic [2:0] ACT_ERASE   = 3'd1;
    localparam logic [2:0] ACT_START   = 3'd2;
    localparam logic [2:0] ACT_DATA    = 3'd3;
    localparam logic [2:0] ACT_CONFIRM = 3'd4;
    localparam logic [2:0] ACT_SAMPLE  = 3'd5;
    localparam logic [2:0] ACT_TICK    = 3'd6;

    // Status report codes
    localparam logic [2:0] ST_DONE       = 3'd0;
    localparam logic [2:0] ST_BAD_SECTOR = 3'd1;
    localparam logic [2:0] ST_BUSY       = 3'd2;
    localparam logic [2:0] ST_TIMEOUT    = 3'd3;
    localparam logic [2:0] ST_SEQ_ERROR  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_BYTE_MODE     = 2'd0;
    localparam logic [1:0] CFG_PROG_TIMEOUT  = 2'd1;
    localparam logic [1:0] CFG_ERASE_TIMEOUT = 2'd2;

    // Result kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Flash command bytes
    localparam logic [15:0] CMD_UNLOCK_A     = 16'h00AA;
    localparam logic [15:0] CMD_UNLOCK_B     = 16'h0055;
    localparam logic [15:0] CMD_ERASE_SETUP  = 16'h0080;
    localparam logic [15:0] CMD_SECTOR_ERASE = 16'h0030;
    localparam logic [15:0] CMD_WRITE_BUFFER = 16'h0025;
    localparam logic [15:0] CMD_BUF_CONFIRM  = 16'h0029;
    localparam logic [15:0] CMD_RESET        = 16'h00F0;

    // Unlock addresses for 16-bit and 8-bit bus modes
    localparam logic [23:0] UNLOCK1_WORD = 24'h000555;
    localparam logic [23:0] UNLOCK2_WORD = 24'h0002AA;
    localparam logic [23:0] UNLOCK1_BYTE = 24'h000AAA;
    localparam logic [23:0] UNLOCK2_BYTE = 24'h000555;

    localparam logic [21:0] TICK_MAX = 22'h3FFFFF;

    // Reset values of the configuration registers
    localparam logic [15:0] PROG_TIMEOUT_RST  = 16'd1200;
    localparam logic [21:0] ERASE_TIMEOUT_RST = 22'd3500000;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  sector_number;
        logic [24:0] target_address;
        logic [8:0]  unit_count;
        logic [15:0] data_word;
        logic [15:0] status_read;
    } req_t;

    typedef struct packed {
        logic        result_kind;
        logic [23:0] bus_address;
        logic [15:0] bus_data;
        logic [2:0]  status_code;
        logic        last_of_run;
    } rsp_t;

    typedef struct packed {
        logic        byte_mode;
        logic [15:0] prog_timeout;
        logic [21:0] erase_timeout;
    } cfg_t;

    typedef enum logic [2:0] {
        JOB_RESET,
        JOB_ERASE,
        JOB_START,
        JOB_DATA,
        JOB_CONFIRM,
        JOB_STATUS
    } job_kind_t;

    // One classified request waiting for the bus sequencer
    typedef struct packed {
        job_kind_t   kind;
        logic        byte_mode;
        logic [23:0] addr;
        logic [15:0] data;
        logic [2:0]  code;
    } job_t;

endpackage

### rtl/nfcs_front.sv
// Front end: accepts requests, checks them against the flash state and queues jobs.
module nfcs_front
    import nfcs_pkg::*;
#(
    parameter int SECTOR_COUNT = 256,
    parameter int SECTOR_BYTES = 131072,
    parameter int BUFFER_UNITS = 256
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  logic req_valid,
    output logic req_stall,
    input  cfg_t cfg,
    input  logic queue_full,
    output logic job_push,
    output job_t job
);

    // Sector of a byte address by reciprocal multiplication (exact for 25-bit input)
    localparam int ADDR_W = 25;
    localparam int SB_LOG = $clog2(SECTOR_BYTES);
    localparam int SHIFT  = ADDR_W + SB_LOG;
    localparam longint RECIP = ((64'd1 << SHIFT) + 64'(SECTOR_BYTES) - 64'd1)
                               / 64'(SECTOR_BYTES);
    localparam int RECIP_W = ADDR_W + 1;
    localparam int QW      = 26 - SB_LOG;
    localparam int SB_W    = SB_LOG + 1;
    localparam int PROD_W  = QW + SB_W;

    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
    localparam logic [SB_W-1:0]    SB_C    = SB_W'(SECTOR_BYTES);
    localparam logic [31:0]        SC_C    = 32'(SECTOR_COUNT);
    localparam logic [8:0]         BU_C    = 9'(BUFFER_UNITS);

    logic                        valid_a_reg, valid_a_next;
    req_t                        req_a_reg;
    logic [QW-1:0]               quot_a_reg;
    logic [ADDR_W+RECIP_W-1:0]   recip_prod;
    logic                        accept, fire;

    logic                        busy_reg, busy_next;
    logic                        busy_erase_reg, busy_erase_next;
    logic [15:0]                 prev_sample_reg, prev_sample_next;
    logic                        have_prev_reg, have_prev_next;
    logic [21:0]                 elapsed_reg, elapsed_next;
    logic                        in_prog_reg, in_prog_next;
    logic [23:0]                 wr_ptr_reg, wr_ptr_next;
    logic [23:0]                 base_reg, base_next;
    logic [8:0]                  remaining_reg, remaining_next;

    logic [QW-1:0]               sec;
    logic [PROD_W-1:0]           base_prod;
    logic [23:0]                 base_calc;
    logic                        sec_bad;
    logic [21:0]                 tick_inc;
    logic [21:0]                 limit;

    // Input stage: register the request with its sector quotient
    assign req_stall    = valid_a_reg & queue_full;
    assign accept       = req_valid & ~req_stall;
    assign fire         = valid_a_reg & ~queue_full;
    assign recip_prod   = req.target_address * RECIP_C;
    assign valid_a_next = accept | (valid_a_reg & ~fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= valid_a_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_a_reg  <= req;
            quot_a_reg <= recip_prod[SHIFT +: QW];
        end
    end

    // Sector range and base word address
    assign sec       = (req_a_reg.action == ACT_ERASE) ?
                       QW'(req_a_reg.sector_number) : quot_a_reg;
    assign sec_bad   = 32'(sec) >= SC_C;
    assign base_prod = PROD_W'(sec) * PROD_W'(SB_C);
    assign base_calc = 24'(base_prod >> 1);
    assign tick_inc  = (elapsed_reg < TICK_MAX) ? elapsed_reg + 22'd1 : elapsed_reg;
    assign limit     = busy_erase_reg ? cfg.erase_timeout : {6'd0, cfg.prog_timeout};

    // Classification and state update
    always_comb
    begin
        busy_next       = busy_reg;
        busy_erase_next = busy_erase_reg;
        prev_sample_next = prev_sample_reg;
        have_prev_next  = have_prev_reg;
        elapsed_next    = elapsed_reg;
        in_prog_next    = in_prog_reg;
        wr_ptr_next     = wr_ptr_reg;
        base_next       = base_reg;
        remaining_next  = remaining_reg;
        job_push        = 1'b0;
        job.kind        = JOB_STATUS;
        job.byte_mode   = cfg.byte_mode;
        job.addr        = 24'd0;
        job.data        = 16'd0;
        job.code        = ST_DONE;

        if (fire)
        begin
            case (req_a_reg.action)
                ACT_RESET:
                begin
                    job_push        = 1'b1;
                    job.kind        = JOB_RESET;
                    busy_next       = 1'b0;
                    busy_erase_next = 1'b0;
                    have_prev_next  = 1'b0;
                    elapsed_next    = 22'd0;
                    in_prog_next    = 1'b0;
                    remaining_next  = 9'd0;
                end
                ACT_ERASE:
                begin
                    job_push = 1'b1;
                    if (sec_bad)
                        job.code = ST_BAD_SECTOR;
                    else if (busy_reg)
                        job.code = ST_BUSY;
                    else if (in_prog_reg)
                        job.code = ST_SEQ_ERROR;
                    else
                    begin
                        job.kind        = JOB_ERASE;
                        job.addr        = base_calc;
                        busy_next       = 1'b1;
                        busy_erase_next = 1'b1;
                        elapsed_next    = 22'd0;
                        have_prev_next  = 1'b0;
                    end
                end
                ACT_START:
                begin
                    job_push = 1'b1;
                    if (sec_bad)
                        job.code = ST_BAD_SECTOR;
                    else if (busy_reg)
                        job.code = ST_BUSY;
                    else if (in_prog_reg)
                        job.code = ST_SEQ_ERROR;
                    else if (req_a_reg.unit_count == 9'd0 || req_a_reg.unit_count > BU_C)
                        job.code = ST_SEQ_ERROR;
                    else
                    begin
                        job.kind       = JOB_START;
                        job.addr       = base_calc;
                        job.data       = {7'd0, req_a_reg.unit_count - 9'd1};
                        base_next      = base_calc;
                        wr_ptr_next    = req_a_reg.target_address[24:1];
                        remaining_next = req_a_reg.unit_count;
                        in_prog_next   = 1'b1;
                    end
                end
                ACT_DATA:
                begin
                    job_push = 1'b1;
                    if (!in_prog_reg || remaining_reg == 9'd0)
                        job.code = ST_SEQ_ERROR;
                    else
                    begin
                        job.kind       = JOB_DATA;
                        job.addr       = wr_ptr_reg;
                        job.data       = req_a_reg.data_word;
                        wr_ptr_next    = wr_ptr_reg + 24'd1;
                        remaining_next = remaining_reg - 9'd1;
                    end
                end
                ACT_CONFIRM:
                begin
                    job_push = 1'b1;
                    if (!in_prog_reg || remaining_reg != 9'd0)
                        job.code = ST_SEQ_ERROR;
                    else
                    begin
                        job.kind        = JOB_CONFIRM;
                        job.addr        = base_reg;
                        in_prog_next    = 1'b0;
                        busy_next       = 1'b1;
                        busy_erase_next = 1'b0;
                        elapsed_next    = 22'd0;
                        have_prev_next  = 1'b0;
                    end
                end
                ACT_SAMPLE:
                begin
                    job_push = 1'b1;
                    if (!busy_reg)
                        job.code = ST_DONE;
                    else if (have_prev_reg && req_a_reg.status_read == prev_sample_reg)
                    begin
                        job.code       = ST_DONE;
                        busy_next      = 1'b0;
                        have_prev_next = 1'b0;
                    end
                    else
                    begin
                        job.code         = ST_BUSY;
                        prev_sample_next = req_a_reg.status_read;
                        have_prev_next   = 1'b1;
                    end
                end
                ACT_TICK:
                begin
                    if (busy_reg)
                    begin
                        elapsed_next = tick_inc;
                        if (tick_inc >= limit)
                        begin
                            job_push       = 1'b1;
                            job.code       = ST_TIMEOUT;
                            busy_next      = 1'b0;
                            have_prev_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    job_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            busy_erase_reg  <= 1'b0;
            prev_sample_reg <= 16'd0;
            have_prev_reg   <= 1'b0;
            elapsed_reg     <= 22'd0;
            in_prog_reg     <= 1'b0;
            wr_ptr_reg      <= 24'd0;
            base_reg        <= 24'd0;
            remaining_reg   <= 9'd0;
        end
        else
        begin
            busy_reg        <= busy_next;
            busy_erase_reg  <= busy_erase_next;
            prev_sample_reg <= prev_sample_next;
            have_prev_reg   <= have_prev_next;
            elapsed_reg     <= elapsed_next;
            in_prog_reg     <= in_prog_next;
            wr_ptr_reg      <= wr_ptr_next;
            base_reg        <= base_next;
            remaining_reg   <= remaining_next;
        end
    end

endmodule

### rtl/nfcs_queue.sv
// Short job queue between the request front end and the bus sequencer.
module nfcs_queue
    import nfcs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic head_valid,
    output job_t head,
    input  logic pop
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    job_t               entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;
    logic               do_push, do_pop;

    assign full       = count_reg == (PTR_W+1)'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

### rtl/nfcs_back.sv
// Bus sequencer: expands each queued job into flash bus writes or a status report.
module nfcs_back
    import nfcs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic head_valid,
    input  job_t head,
    output logic pop,
    output rsp_t rsp,
    output logic rsp_valid,
    input  logic rsp_stall
);

    logic [2:0]  step_reg, step_next;
    logic        out_valid_reg, out_valid_next;
    rsp_t        out_reg;
    rsp_t        cur;
    logic        last;
    logic        load;
    logic [23:0] unlock1, unlock2;

    assign unlock1 = head.byte_mode ? UNLOCK1_BYTE : UNLOCK1_WORD;
    assign unlock2 = head.byte_mode ? UNLOCK2_BYTE : UNLOCK2_WORD;

    // Result for the current step of the head job
    always_comb
    begin
        cur.result_kind = KIND_WRITE;
        cur.bus_address = 24'd0;
        cur.bus_data    = 16'd0;
        cur.status_code = ST_DONE;
        last            = 1'b1;
        case (head.kind)
            JOB_RESET:
            begin
                cur.bus_data = CMD_RESET;
            end
            JOB_ERASE:
            begin
                last = step_reg == 3'd5;
                case (step_reg)
                    3'd0:
                    begin
                        cur.bus_address = unlock1;
                        cur.bus_data    = CMD_UNLOCK_A;
                    end
                    3'd1:
                    begin
                        cur.bus_address = unlock2;
                        cur.bus_data    = CMD_UNLOCK_B;
                    end
                    3'd2:
                    begin
                        cur.bus_address = unlock1;
                        cur.bus_data    = CMD_ERASE_SETUP;
                    end
                    3'd3:
                    begin
                        cur.bus_address = unlock1;
                        cur.bus_data    = CMD_UNLOCK_A;
                    end
                    3'd4:
                    begin
                        cur.bus_address = unlock2;
                        cur.bus_data    = CMD_UNLOCK_B;
                    end
                    default:
                    begin
                        cur.bus_address = head.addr;
                        cur.bus_data    = CMD_SECTOR_ERASE;
                    end
                endcase
            end
            JOB_START:
            begin
                last = step_reg == 3'd3;
                case (step_reg)
                    3'd0:
                    begin
                        cur.bus_address = unlock1;
                        cur.bus_data    = CMD_UNLOCK_A;
                    end
                    3'd1:
                    begin
                        cur.bus_address = unlock2;
                        cur.bus_data    = CMD_UNLOCK_B;
                    end
                    3'd2:
                    begin
                        cur.bus_address = head.addr;
                        cur.bus_data    = CMD_WRITE_BUFFER;
                    end
                    default:
                    begin
                        cur.bus_address = head.addr;
                        cur.bus_data    = head.data;
                    end
                endcase
            end
            JOB_DATA:
            begin
                cur.bus_address = head.addr;
                cur.bus_data    = head.data;
            end
            JOB_CONFIRM:
            begin
                cur.bus_address = head.addr;
                cur.bus_data    = CMD_BUF_CONFIRM;
            end
            JOB_STATUS:
            begin
                cur.result_kind = KIND_STATUS;
                cur.status_code = head.code;
            end
            default:
            begin
                cur.result_kind = KIND_STATUS;
                cur.status_code = head.code;
            end
        endcase
        cur.last_of_run = last;
    end

    // Output register handshake
    assign load           = head_valid & (~out_valid_reg | ~rsp_stall);
    assign pop            = load & last;
    assign step_next      = load ? (last ? 3'd0 : step_reg + 3'd1) : step_reg;
    assign out_valid_next = load | (out_valid_reg & rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= cur;
    end

    assign rsp       = out_reg;
    assign rsp_valid = out_valid_reg;

endmodule

### rtl/nor_flash_command_sequencer.sv
// Top level of the NOR flash command sequencer: configuration registers and the three parts.
//
// Requests arrive on req/req_valid/req_stall; one item is one request (reset, erase,
// buffer program start/data/confirm, status sample or tick). Results leave on
// rsp/rsp_valid/rsp_stall: each is a flash bus write or a status report, and
// last_of_run marks the final result of a request. A tick while idle gives nothing.
// The front end registers a request, then checks it against the flash state and
// queues a job (four deep); the bus sequencer expands each job into results.
// The first result of a request passes the input register, the queue and the output
// register. Throughput: one result per cycle from the output register while rsp_stall
// is low; an erase gives six results, a program start four and any other job one.
// Requests keep being accepted while the queue has room. When the receiver stalls,
// the output item holds, the queue fills and then req_stall rises. Reset clears busy
// and program state and loads the configuration defaults (16-bit bus unlock addresses,
// 1200 program ticks, 3500000 erase ticks). Configuration is written through
// cfg_write/cfg_index/cfg_data, by the user only while idle; the block does not enforce it.
module nor_flash_command_sequencer
    import nfcs_pkg::*;
#(
    parameter int SECTOR_COUNT = 256,
    parameter int SECTOR_BYTES = 131072,
    parameter int BUFFER_UNITS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  req_t        req,
    input  logic        req_valid,
    output logic        req_stall,
    output rsp_t        rsp,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [21:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic queue_full;
    logic job_push;
    job_t job;
    logic head_valid;
    job_t head;
    logic pop;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_BYTE_MODE:     cfg_next.byte_mode     = cfg_data[0];
                CFG_PROG_TIMEOUT:  cfg_next.prog_timeout  = cfg_data[15:0];
                CFG_ERASE_TIMEOUT: cfg_next.erase_timeout = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.byte_mode     <= 1'b0;
            cfg_reg.prog_timeout  <= PROG_TIMEOUT_RST;
            cfg_reg.erase_timeout <= ERASE_TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    nfcs_front #(
        .SECTOR_COUNT (SECTOR_COUNT),
        .SECTOR_BYTES (SECTOR_BYTES),
        .BUFFER_UNITS (BUFFER_UNITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .job_push   (job_push),
        .job        (job)
    );

    nfcs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_job   (job),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    nfcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .rsp        (rsp),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall)
    );

endmodule
